// ===== rtl/pid_controller_clamped_assert.svh =====
// Assertion macros shared by the PID controller RTL.
`ifndef PID_CONTROLLER_CLAMPED_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCC_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid_controller_clamped: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid_controller_clamped: assertion failed");

`endif

// ===== rtl/pcc_pkg.sv =====
// Shared constants, types and width helpers for the PID controller.
package pcc_pkg;

  localparam int GainWidth    = 24;
  localparam int LimitWidth   = 31;
  localparam int DriveWidth   = 32;
  localparam int SumWidth     = 32;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 32;

  localparam logic [CfgIdxWidth-1:0] RegPropGain    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegIntegGain   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegDerivGain   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegIntegLimit  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegOutputLimit = 3'd4;

  typedef struct packed {
    logic integ_clamped;
    logic output_clamped;
  } pcc_flags_t;

  // Width that holds P + I + D without overflow for a given sample width.
  function automatic int pcc_total_width(int sample_width);
    int widest;
    widest = (sample_width + 2 > SumWidth) ? sample_width + 2 : SumWidth;
    return GainWidth + widest + 2;
  endfunction

endpackage

// ===== rtl/pcc_front.sv =====
// Error formation, saturating error accumulator and error difference stage.
module pcc_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           load_i,
  input  logic signed [SAMPLE_WIDTH-1:0] target_i,
  input  logic signed [SAMPLE_WIDTH-1:0] measured_i,
  output logic signed [SAMPLE_WIDTH:0]   err_o,
  output logic signed [pcc_pkg::SumWidth-1:0] sum_o,
  output logic signed [SAMPLE_WIDTH+1:0] derr_o
);

  localparam int ErrWidth  = SAMPLE_WIDTH + 1;
  localparam int DerrWidth = SAMPLE_WIDTH + 2;
  localparam int AccWidth  =
    ((ErrWidth > pcc_pkg::SumWidth) ? ErrWidth : pcc_pkg::SumWidth) + 1;

  localparam logic signed [AccWidth-1:0] AccMax =
    {{(AccWidth - pcc_pkg::SumWidth + 1){1'b0}}, {(pcc_pkg::SumWidth-1){1'b1}}};
  localparam logic signed [AccWidth-1:0] AccMin =
    {{(AccWidth - pcc_pkg::SumWidth + 1){1'b1}}, {(pcc_pkg::SumWidth-1){1'b0}}};

  logic signed [ErrWidth-1:0]          err;
  logic signed [AccWidth-1:0]          acc_wide;
  logic signed [pcc_pkg::SumWidth-1:0] sum_sat;
  logic signed [DerrWidth-1:0]         derr;

  logic signed [pcc_pkg::SumWidth-1:0] error_sum_q;
  logic signed [ErrWidth-1:0]          last_error_q;
  logic signed [ErrWidth-1:0]          err_q;
  logic signed [pcc_pkg::SumWidth-1:0] sum_q;
  logic signed [DerrWidth-1:0]         derr_q;

  assign err      = ErrWidth'(target_i) - ErrWidth'(measured_i);
  assign acc_wide = AccWidth'(error_sum_q) + AccWidth'(err);
  assign derr     = DerrWidth'(err) - DerrWidth'(last_error_q);

  // The accumulator sticks at whichever 32-bit bound it would pass.
  always_comb begin
    if (acc_wide > AccMax) begin
      sum_sat = AccMax[pcc_pkg::SumWidth-1:0];
    end else if (acc_wide < AccMin) begin
      sum_sat = AccMin[pcc_pkg::SumWidth-1:0];
    end else begin
      sum_sat = acc_wide[pcc_pkg::SumWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else if (accept_i) begin
      error_sum_q  <= sum_sat;
      last_error_q <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q  <= err;
      sum_q  <= sum_sat;
      derr_q <= derr;
    end
  end

  assign err_o  = err_q;
  assign sum_o  = sum_q;
  assign derr_o = derr_q;

endmodule

// ===== rtl/pcc_mult.sv =====
// Gain multiplication stage: three parallel products, each scaled down by the fraction bits.
module pcc_mult #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   load_i,
  input  logic signed [SAMPLE_WIDTH:0]           err_i,
  input  logic signed [pcc_pkg::SumWidth-1:0]    sum_i,
  input  logic signed [SAMPLE_WIDTH+1:0]         derr_i,
  input  logic signed [pcc_pkg::GainWidth-1:0]   kp_i,
  input  logic signed [pcc_pkg::GainWidth-1:0]   ki_i,
  input  logic signed [pcc_pkg::GainWidth-1:0]   kd_i,
  output logic signed [pcc_pkg::GainWidth+SAMPLE_WIDTH:0]   p_o,
  output logic signed [pcc_pkg::GainWidth+pcc_pkg::SumWidth-1:0] i_o,
  output logic signed [pcc_pkg::GainWidth+SAMPLE_WIDTH+1:0] d_o
);

  localparam int PWidth = pcc_pkg::GainWidth + SAMPLE_WIDTH + 1;
  localparam int IWidth = pcc_pkg::GainWidth + pcc_pkg::SumWidth;
  localparam int DWidth = pcc_pkg::GainWidth + SAMPLE_WIDTH + 2;

  logic signed [PWidth-1:0] p_full;
  logic signed [IWidth-1:0] i_full;
  logic signed [DWidth-1:0] d_full;

  logic signed [PWidth-1:0] p_q;
  logic signed [IWidth-1:0] i_q;
  logic signed [DWidth-1:0] d_q;

  // Operands are sign extended to the product width, so the low bits are exact.
  assign p_full = PWidth'(kp_i) * PWidth'(err_i);
  assign i_full = IWidth'(ki_i) * IWidth'(sum_i);
  assign d_full = DWidth'(kd_i) * DWidth'(derr_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_q <= p_full >>> GAIN_FRAC_BITS;
      i_q <= i_full >>> GAIN_FRAC_BITS;
      d_q <= d_full >>> GAIN_FRAC_BITS;
    end
  end

  assign p_o = p_q;
  assign i_o = i_q;
  assign d_o = d_q;

endmodule

// ===== rtl/pcc_combine.sv =====
// Integral term clamp and summation of the three terms.
module pcc_combine #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   load_i,
  input  logic signed [pcc_pkg::GainWidth+SAMPLE_WIDTH:0]   p_i,
  input  logic signed [pcc_pkg::GainWidth+pcc_pkg::SumWidth-1:0] i_i,
  input  logic signed [pcc_pkg::GainWidth+SAMPLE_WIDTH+1:0] d_i,
  input  logic        [pcc_pkg::LimitWidth-1:0]  integ_limit_i,
  output logic signed [pcc_pkg::pcc_total_width(SAMPLE_WIDTH)-1:0] total_o,
  output logic                                   integ_hit_o
);

  localparam int TotWidth = pcc_pkg::pcc_total_width(SAMPLE_WIDTH);

  logic signed [TotWidth-1:0] i_ext;
  logic signed [TotWidth-1:0] lim;
  logic signed [TotWidth-1:0] i_clamped;
  logic                       integ_hit;
  logic signed [TotWidth-1:0] total;

  logic signed [TotWidth-1:0] total_q;
  logic                       integ_hit_q;

  assign i_ext = TotWidth'(i_i);
  assign lim   = TotWidth'({1'b0, integ_limit_i});

  // A zero limit leaves the integral term untouched.
  always_comb begin
    i_clamped = i_ext;
    integ_hit = 1'b0;
    if (integ_limit_i != '0) begin
      if (i_ext > lim) begin
        i_clamped = lim;
        integ_hit = 1'b1;
      end else if (i_ext < -lim) begin
        i_clamped = -lim;
        integ_hit = 1'b1;
      end
    end
  end

  assign total = TotWidth'(p_i) + i_clamped + TotWidth'(d_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      total_q     <= total;
      integ_hit_q <= integ_hit;
    end
  end

  assign total_o     = total_q;
  assign integ_hit_o = integ_hit_q;

endmodule

// ===== rtl/pcc_limit.sv =====
// Output clamp, 32-bit saturation and result register.
module pcc_limit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   load_i,
  input  logic signed [pcc_pkg::pcc_total_width(SAMPLE_WIDTH)-1:0] total_i,
  input  logic                                   integ_hit_i,
  input  logic        [pcc_pkg::LimitWidth-1:0]  output_limit_i,
  output logic signed [pcc_pkg::DriveWidth-1:0]  drive_o,
  output pcc_pkg::pcc_flags_t                    flags_o
);

  localparam int TotWidth = pcc_pkg::pcc_total_width(SAMPLE_WIDTH);

  localparam logic signed [TotWidth-1:0] TotMax =
    {{(TotWidth - pcc_pkg::DriveWidth + 1){1'b0}}, {(pcc_pkg::DriveWidth-1){1'b1}}};
  localparam logic signed [TotWidth-1:0] TotMin =
    {{(TotWidth - pcc_pkg::DriveWidth + 1){1'b1}}, {(pcc_pkg::DriveWidth-1){1'b0}}};

  logic signed [TotWidth-1:0]            lim;
  logic signed [TotWidth-1:0]            neg_lim;
  logic signed [pcc_pkg::DriveWidth-1:0] drive;
  logic                                  out_hit;

  logic signed [pcc_pkg::DriveWidth-1:0] drive_q;
  pcc_pkg::pcc_flags_t                   flags_q;

  assign lim     = TotWidth'({1'b0, output_limit_i});
  assign neg_lim = -lim;

  // With a nonzero limit the clamped value always fits in 32 bits, so the
  // saturation only acts when the limit is off.
  always_comb begin
    drive   = total_i[pcc_pkg::DriveWidth-1:0];
    out_hit = 1'b0;
    if (output_limit_i != '0) begin
      if (total_i > lim) begin
        drive   = lim[pcc_pkg::DriveWidth-1:0];
        out_hit = 1'b1;
      end else if (total_i < neg_lim) begin
        drive   = neg_lim[pcc_pkg::DriveWidth-1:0];
        out_hit = 1'b1;
      end
    end else if (total_i > TotMax) begin
      drive   = TotMax[pcc_pkg::DriveWidth-1:0];
      out_hit = 1'b1;
    end else if (total_i < TotMin) begin
      drive   = TotMin[pcc_pkg::DriveWidth-1:0];
      out_hit = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q                <= drive;
      flags_q.integ_clamped  <= integ_hit_i;
      flags_q.output_clamped <= out_hit;
    end
  end

  assign drive_o = drive_q;
  assign flags_o = flags_q;

endmodule

// ===== rtl/pid_controller_clamped.sv =====
// Top level of the clamped fixed-point PID controller.
// Each request carries a setpoint and a measurement; the block returns one result per request
// with the controller output and two clamp flags. It takes one request per clock cycle while
// in_stall_o is low. A request passes through the four stages in order, each closed by a
// register: error and saturating accumulator, the three gain multipliers, integral clamp and
// term sum, then output clamp and saturation. The accumulator update closes on its own
// register, so back-to-back requests see each other's state. A stall on the output
// backs up through the four stages and only reaches the input when all of them hold data.
// The user must write gains and limits through the configuration port only while no request
// is in flight; the block itself does not enforce this.
module pid_controller_clamped #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]        target_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        measured_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pcc_pkg::DriveWidth-1:0] drive_value_o,
  output logic                                  integ_clamped_o,
  output logic                                  output_clamped_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pcc_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [pcc_pkg::CfgDataWidth-1:0]      cfg_data_i
);

`include "pid_controller_clamped_assert.svh"

  localparam int TotWidth = pcc_pkg::pcc_total_width(SAMPLE_WIDTH);

  logic [pcc_pkg::GainWidth-1:0]  prop_gain_q;
  logic [pcc_pkg::GainWidth-1:0]  integ_gain_q;
  logic [pcc_pkg::GainWidth-1:0]  deriv_gain_q;
  logic [pcc_pkg::LimitWidth-1:0] integ_limit_q;
  logic [pcc_pkg::LimitWidth-1:0] output_limit_q;

  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic accept;

  logic signed [SAMPLE_WIDTH:0]                          err;
  logic signed [pcc_pkg::SumWidth-1:0]                   sum;
  logic signed [SAMPLE_WIDTH+1:0]                        derr;
  logic signed [pcc_pkg::GainWidth+SAMPLE_WIDTH:0]       p_term;
  logic signed [pcc_pkg::GainWidth+pcc_pkg::SumWidth-1:0] i_term;
  logic signed [pcc_pkg::GainWidth+SAMPLE_WIDTH+1:0]     d_term;
  logic signed [TotWidth-1:0]                            total;
  logic                                                  integ_hit;
  pcc_pkg::pcc_flags_t                                   flags;

  logic                                  pipe_full_stalled;
  logic signed [pcc_pkg::DriveWidth-1:0] out_lim_s;
  logic                                  drive_in_limit;

  // Configuration registers; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= '0;
      integ_gain_q   <= '0;
      deriv_gain_q   <= '0;
      integ_limit_q  <= '0;
      output_limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pcc_pkg::RegPropGain: begin
          prop_gain_q <= cfg_data_i[pcc_pkg::GainWidth-1:0];
        end
        pcc_pkg::RegIntegGain: begin
          integ_gain_q <= cfg_data_i[pcc_pkg::GainWidth-1:0];
        end
        pcc_pkg::RegDerivGain: begin
          deriv_gain_q <= cfg_data_i[pcc_pkg::GainWidth-1:0];
        end
        pcc_pkg::RegIntegLimit: begin
          integ_limit_q <= cfg_data_i[pcc_pkg::LimitWidth-1:0];
        end
        pcc_pkg::RegOutputLimit: begin
          output_limit_q <= cfg_data_i[pcc_pkg::LimitWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A stage takes new data when it is empty or its content moves on.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s3_ready   = !s3_valid_q || out_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign accept     = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  pcc_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .load_i    (s1_ready),
    .target_i  (target_value_i),
    .measured_i(measured_value_i),
    .err_o     (err),
    .sum_o     (sum),
    .derr_o    (derr)
  );

  pcc_mult #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_mult (
    .clk_i (clk_i),
    .load_i(s2_ready),
    .err_i (err),
    .sum_i (sum),
    .derr_i(derr),
    .kp_i  ($signed(prop_gain_q)),
    .ki_i  ($signed(integ_gain_q)),
    .kd_i  ($signed(deriv_gain_q)),
    .p_o   (p_term),
    .i_o   (i_term),
    .d_o   (d_term)
  );

  pcc_combine #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_combine (
    .clk_i        (clk_i),
    .load_i       (s3_ready),
    .p_i          (p_term),
    .i_i          (i_term),
    .d_i          (d_term),
    .integ_limit_i(integ_limit_q),
    .total_o      (total),
    .integ_hit_o  (integ_hit)
  );

  pcc_limit #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_limit (
    .clk_i         (clk_i),
    .load_i        (out_ready),
    .total_i       (total),
    .integ_hit_i   (integ_hit),
    .output_limit_i(output_limit_q),
    .drive_o       (drive_value_o),
    .flags_o       (flags)
  );

  assign out_valid_o      = out_valid_q;
  assign integ_clamped_o  = flags.integ_clamped;
  assign output_clamped_o = flags.output_clamped;

  assign pipe_full_stalled = out_valid_q && out_stall_i && s1_valid_q && s2_valid_q && s3_valid_q;
  assign out_lim_s         = $signed({1'b0, output_limit_q});
  assign drive_in_limit    = (drive_value_o <= out_lim_s) && (drive_value_o >= -out_lim_s);

  // Backpressure at the input can only come from a full pipeline behind a stalled output.
  `PCC_ASSERT_HOLDS(a_stall_source, clk_i, rst_ni, in_stall_o, pipe_full_stalled)
  `PCC_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, accept, s1_valid_q)
  `PCC_ASSERT_HOLDS(a_drive_in_limit, clk_i, rst_ni, out_valid_q && (output_limit_q != '0), drive_in_limit)
  `PCC_ASSERT_HOLDS(a_integ_flag_needs_limit, clk_i, rst_ni, out_valid_q && integ_clamped_o, integ_limit_q != '0)

endmodule
